### rtl/core/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg - shared types and constants of the 1-Wire ROM search engine
// Item layouts, command and status codes, CRC and ROM geometry.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int unsigned ROM_BITS  = 64;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DISC_W    = 8;
  localparam int unsigned CRC_W     = 8;
  localparam int unsigned CRC_BYTES = 7;
  localparam int unsigned CRC_BITS  = CRC_BYTES * 8;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 8'h8C;
  localparam logic [DISC_W-1:0] DISC_NONE  = 8'hFF;
  localparam logic [DISC_W-1:0] DISC_FRESH = DISC_W'(ROM_BITS);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(ROM_BITS - 1);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BIT     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_BIT_DONE    = 3'd0,
    ST_STARTED     = 3'd1,
    ST_FINISHED    = 3'd2,
    ST_NO_PRESENCE = 3'd3,
    ST_NO_RESPONSE = 3'd4,
    ST_FOUND       = 3'd5,
    ST_CRC_ERROR   = 3'd6,
    ST_IGNORED     = 3'd7
  } status_t;

  typedef struct packed {
    kind_t kind;
    logic  presence;
    logic  id_bit;
    logic  cmp_bit;
  } cmd_t;

  typedef struct packed {
    logic                write_bit;
    status_t             status;
    logic [POS_W-1:0]    bit_index;
    logic [ROM_BITS-1:0] rom_id;
  } rsp_t;

endpackage

### rtl/core/ors_core.sv
// ----------------------------------------------------------------------------
// ors_core - search state and per-item step
// Holds the committed and working search state and works out one result
// per command in a single pass of logic.
// ----------------------------------------------------------------------------
module ors_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  ors_pkg::cmd_t cmd,
  output ors_pkg::rsp_t rsp
);

  logic [ors_pkg::ROM_BITS-1:0] committed_id, committed_id_next;
  logic [ors_pkg::DISC_W-1:0]   committed_disc, committed_disc_next;
  logic [ors_pkg::ROM_BITS-1:0] working_id, working_id_next;
  logic [ors_pkg::DISC_W-1:0]   working_disc, working_disc_next;
  logic [ors_pkg::CRC_W-1:0]    crc, crc_next;
  logic [ors_pkg::POS_W-1:0]    bit_pos, bit_pos_next;
  logic                         pass_active, pass_active_next;

  logic [ors_pkg::ROM_BITS-1:0] mask, keep;
  logic                         dir, fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_id   <= '0;
      committed_disc <= ors_pkg::DISC_FRESH;
      working_id     <= '0;
      working_disc   <= ors_pkg::DISC_NONE;
      crc            <= '0;
      bit_pos        <= '0;
      pass_active    <= 1'b0;
    end else if (fire) begin
      committed_id   <= committed_id_next;
      committed_disc <= committed_disc_next;
      working_id     <= working_id_next;
      working_disc   <= working_disc_next;
      crc            <= crc_next;
      bit_pos        <= bit_pos_next;
      pass_active    <= pass_active_next;
    end
  end

  always_comb begin
    committed_id_next   = committed_id;
    committed_disc_next = committed_disc;
    working_id_next     = working_id;
    working_disc_next   = working_disc;
    crc_next            = crc;
    bit_pos_next        = bit_pos;
    pass_active_next    = pass_active;
    mask = ors_pkg::ROM_BITS'(1) << bit_pos;
    // bits up to and including the discrepancy position
    keep = ~((~ors_pkg::ROM_BITS'(0) << committed_disc[ors_pkg::POS_W-1:0]) << 1);
    dir  = 1'b0;
    fb   = 1'b0;
    rsp.write_bit = 1'b0;
    rsp.status    = ors_pkg::ST_IGNORED;
    rsp.bit_index = '0;

    case (cmd.kind)
      ors_pkg::KIND_START: begin
        pass_active_next = 1'b0;
        if (committed_disc == ors_pkg::DISC_NONE) begin
          rsp.status = ors_pkg::ST_FINISHED;
        end else begin
          working_id_next = committed_id;
          if (committed_disc < ors_pkg::DISC_FRESH) begin
            working_id_next = (committed_id & keep) |
                              (ors_pkg::ROM_BITS'(1) << committed_disc[ors_pkg::POS_W-1:0]);
          end
          working_disc_next = ors_pkg::DISC_NONE;
          crc_next          = '0;
          bit_pos_next      = '0;
          if (cmd.presence) begin
            pass_active_next = 1'b1;
            rsp.status       = ors_pkg::ST_STARTED;
          end else begin
            rsp.status = ors_pkg::ST_NO_PRESENCE;
          end
        end
      end
      ors_pkg::KIND_BIT: begin
        if (!pass_active) begin
          rsp.status = ors_pkg::ST_IGNORED;
        end else if (cmd.id_bit && cmd.cmp_bit) begin
          pass_active_next = 1'b0;
          bit_pos_next     = '0;
          rsp.status       = ors_pkg::ST_NO_RESPONSE;
          rsp.bit_index    = bit_pos;
        end else begin
          if (!cmd.id_bit && !cmd.cmp_bit) begin
            // conflict: keep a 1 already chosen, else take 0 and mark it
            dir = |(working_id & mask);
            if (!dir) begin
              working_disc_next = ors_pkg::DISC_W'(bit_pos);
            end
          end else begin
            dir = cmd.id_bit;
          end
          working_id_next = dir ? (working_id | mask) : (working_id & ~mask);
          if (bit_pos < ors_pkg::POS_W'(ors_pkg::CRC_BITS)) begin
            fb       = crc[0] ^ dir;
            crc_next = (crc >> 1) ^ (fb ? ors_pkg::CRC_POLY : '0);
          end
          rsp.write_bit = dir;
          rsp.bit_index = bit_pos;
          if (bit_pos == ors_pkg::POS_LAST) begin
            pass_active_next = 1'b0;
            bit_pos_next     = '0;
            if (working_id_next[ors_pkg::ROM_BITS-1 -: ors_pkg::CRC_W] == crc_next) begin
              committed_id_next   = working_id_next;
              committed_disc_next = working_disc_next;
              rsp.status          = ors_pkg::ST_FOUND;
            end else begin
              rsp.status = ors_pkg::ST_CRC_ERROR;
            end
          end else begin
            bit_pos_next = bit_pos + 1'b1;
            rsp.status   = ors_pkg::ST_BIT_DONE;
          end
        end
      end
      ors_pkg::KIND_RESTART: begin
        committed_id_next   = '0;
        committed_disc_next = ors_pkg::DISC_FRESH;
        pass_active_next    = 1'b0;
        bit_pos_next        = '0;
        rsp.status          = ors_pkg::ST_STARTED;
      end
      default: begin
        rsp.status = ors_pkg::ST_IGNORED;
      end
    endcase

    rsp.rom_id = working_id_next;
  end

endmodule

### rtl/core/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search - 1-Wire ROM search engine
// Walks the ROM identity tree one device per pass, one bit pair per item.
// ----------------------------------------------------------------------------
// Every command item yields exactly one response item. The block takes one
// item per clock cycle for as long as the response side keeps up; a command
// passes through two registers: the command register takes it when it is
// accepted and feeds the step logic, and the response register loads the
// result when the held command moves on. The whole step for an item - the
// mask update of the working ID, one CRC-8 bit step and, at bit 63, the CRC
// compare and commit - sits in one stretch of logic between those two
// registers, and the search state is written in the same cycle that the
// response register loads, so back-to-back bit pairs see each other's effect.
// A start item (with presence) opens a pass; sixty-four bit-pair items follow;
// the last one reports found or CRC error. A restart clears the committed ID.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ors_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ors_pkg::rsp_t rsp
);

  // command register
  logic          cmd_held_valid;
  ors_pkg::cmd_t cmd_held;
  // response side
  ors_pkg::rsp_t rsp_step;
  logic          advance;
  logic          fire;

  // move the held command on whenever the response register is free or draining
  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = cmd_held_valid && advance;
  assign cmd_stall = cmd_held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held_valid <= 1'b0;
    end else if (!cmd_stall) begin
      cmd_held_valid <= cmd_valid;
    end
  end

  // payload only: hold while stalled
  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      cmd_held <= cmd;
    end
  end

  ors_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (cmd_held),
    .rsp  (rsp_step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= cmd_held_valid;
    end
  end

  // load the response as the state steps; drop nothing while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_step;
    end
  end

endmodule

### rtl/core/ors_checker.sv
// ----------------------------------------------------------------------------
// ors_checker - port-level checks of the ROM search engine
// Watches the response channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module ors_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ors_pkg::rsp_t rsp
);

  logic bit_status;

  assign bit_status = (rsp.status == ors_pkg::ST_BIT_DONE) ||
                      (rsp.status == ors_pkg::ST_FOUND) ||
                      (rsp.status == ors_pkg::ST_CRC_ERROR);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !bit_status |-> !rsp.write_bit)
    else $error("write bit set on a non bit-pair response");

  a_dir_in_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bit_status |-> rsp.rom_id[rsp.bit_index] == rsp.write_bit)
    else $error("direction bit disagrees with working ID");

  a_last_bit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ors_pkg::ST_FOUND ||
                  rsp.status == ors_pkg::ST_CRC_ERROR)
    |-> rsp.bit_index == ors_pkg::POS_LAST)
    else $error("pass closed before the last ROM bit");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ors_pkg::ST_STARTED ||
                  rsp.status == ors_pkg::ST_FINISHED ||
                  rsp.status == ors_pkg::ST_NO_PRESENCE ||
                  rsp.status == ors_pkg::ST_IGNORED)
    |-> rsp.bit_index == '0)
    else $error("bit index set on a non bit-pair response");

endmodule

bind onewire_rom_search ors_checker u_ors_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### dv/onewire_rom_search_check.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_check - scoreboard for the 1-Wire ROM search engine
// Watches both channels, works out the response to every accepted command
// item from its own copy of the search state, and compares each response
// item field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module onewire_rom_search_check
  import ors_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  cmd_t        cmd,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int unsigned errors,
  output int unsigned pending
);

  localparam int unsigned REPORT_CAP = 40;

  // search state as the block should hold it
  logic [ROM_BITS-1:0] saved_rom;
  logic [DISC_W-1:0]   saved_split;
  logic [ROM_BITS-1:0] trial_rom;
  logic [DISC_W-1:0]   trial_split;
  logic [CRC_W-1:0]    crc_acc;
  logic [POS_W-1:0]    next_pos;
  logic                in_pass;

  rsp_t        owed_q[$];
  int unsigned fail_count = 0;

  // Print one line per mismatch, but cap the log if the block is badly off.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Apply one command item to the search state and build its response.
  task automatic search_step(input cmd_t c, output rsp_t r);
    logic [POS_W-1:0]    pos;
    logic [ROM_BITS-1:0] mask;
    logic                dir;
    logic                fb;
    r        = '0;
    r.status = ST_IGNORED;
    case (c.kind)
      KIND_START: begin
        in_pass = 1'b0;
        if (saved_split == DISC_NONE) begin
          r.status = ST_FINISHED;
        end else begin
          trial_rom = saved_rom;
          if (saved_split < ROM_BITS) begin
            mask      = {{(ROM_BITS-1){1'b0}}, 1'b1} << saved_split[POS_W-1:0];
            trial_rom = (trial_rom & (mask | (mask - 1'b1))) | mask;
          end
          trial_split = DISC_NONE;
          crc_acc     = '0;
          next_pos    = '0;
          if (c.presence) begin
            in_pass  = 1'b1;
            r.status = ST_STARTED;
          end else begin
            r.status = ST_NO_PRESENCE;
          end
        end
      end
      KIND_BIT: begin
        if (in_pass) begin
          pos         = next_pos;
          mask        = {{(ROM_BITS-1){1'b0}}, 1'b1} << pos;
          r.bit_index = pos;
          if (c.id_bit && c.cmp_bit) begin
            in_pass  = 1'b0;
            next_pos = '0;
            r.status = ST_NO_RESPONSE;
          end else begin
            // on a conflict keep a 1 already chosen, else go 0 and note it
            if (!c.id_bit && !c.cmp_bit) begin
              dir = (trial_rom & mask) != '0;
              if (!dir)
                trial_split = DISC_W'(pos);
            end else begin
              dir = c.id_bit;
            end
            trial_rom   = dir ? (trial_rom | mask) : (trial_rom & ~mask);
            r.write_bit = dir;
            if (pos < CRC_BITS) begin
              fb      = crc_acc[0] ^ dir;
              crc_acc = crc_acc >> 1;
              if (fb)
                crc_acc = crc_acc ^ CRC_POLY;
            end
            if (pos == POS_LAST) begin
              in_pass  = 1'b0;
              next_pos = '0;
              if (trial_rom[ROM_BITS-1 -: CRC_W] == crc_acc) begin
                saved_rom   = trial_rom;
                saved_split = trial_split;
                r.status    = ST_FOUND;
              end else begin
                r.status = ST_CRC_ERROR;
              end
            end else begin
              next_pos = pos + 1'b1;
              r.status = ST_BIT_DONE;
            end
          end
        end
      end
      KIND_RESTART: begin
        saved_rom   = '0;
        saved_split = DISC_FRESH;
        in_pass     = 1'b0;
        next_pos    = '0;
        r.status    = ST_STARTED;
      end
      default: ;
    endcase
    r.rom_id = trial_rom;
  endtask

  always @(posedge clk) begin : watch
    rsp_t owed;
    rsp_t fresh;
    if (rst) begin
      saved_rom   = '0;
      saved_split = DISC_FRESH;
      trial_rom   = '0;
      trial_split = DISC_NONE;
      crc_acc     = '0;
      next_pos    = '0;
      in_pass     = 1'b0;
      owed_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected response, status", 64'(rsp.status), '0);
        end else begin
          owed = owed_q.pop_front();
          if (rsp.write_bit !== owed.write_bit)
            report_mismatch("write_bit", 64'(rsp.write_bit), 64'(owed.write_bit));
          if (rsp.status !== owed.status)
            report_mismatch("status", 64'(rsp.status), 64'(owed.status));
          if (rsp.bit_index !== owed.bit_index)
            report_mismatch("bit_index", 64'(rsp.bit_index), 64'(owed.bit_index));
          if (rsp.rom_id !== owed.rom_id)
            report_mismatch("rom_id", rsp.rom_id, owed.rom_id);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        search_step(cmd, fresh);
        owed_q.push_back(fresh);
      end
    end
    errors  <= fail_count;
    pending <= owed_q.size();
  end

endmodule

### dv/onewire_rom_search_test.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_test - testbench top of the 1-Wire ROM search engine
// Drives command items onto the block and takes its response items, with
// random idling on both sides; the scoreboard beside the block checks them.
// ----------------------------------------------------------------------------
// The stimulus falls into three kinds of sequence:
//   - scans: a small population of simulated devices sits on a modelled bus.
//     Each search pass sends a start, then one bit pair per ROM bit, and
//     waits for the answer to each bit pair before sending the next, since
//     the devices that still take part depend on the direction bit written.
//     Devices share most of their bits, so the search forks deep in the tree.
//   - streams: one device, whose bit pairs do not depend on the direction,
//     so the pass goes in back to back; now and then a conflict slot or a
//     corrupted ROM bit pushes it into a CRC error.
//   - noise: random items of every kind, the undefined one included.
// Ahead of those sit a handful of directed items, and one stream runs while
// the response side holds off for a long stretch so that the block fills up
// and stalls its command side.
// ----------------------------------------------------------------------------
module onewire_rom_search_test;
  import ors_pkg::*;

  localparam int unsigned ITEM_TARGET     = 750;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned MAX_DEVICES     = 4;
  localparam kind_t       KIND_UNDEF      = kind_t'(2'b11);

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;

  int unsigned mismatches;
  int unsigned pending;

  // handshake bookkeeping shared by the sender and the receiver
  int unsigned issued      = 0;
  int unsigned noise_items = 0;
  int unsigned answered    = 0;
  logic        last_write  = 1'b0;
  status_t     last_status = ST_BIT_DONE;
  logic        rx_hold_req = 1'b0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  // devices on the modelled bus
  logic [ROM_BITS-1:0]    bus_rom [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] bus_live;
  int unsigned            bus_size;

  onewire_rom_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  onewire_rom_search_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL onewire_rom_search");
    $finish;
  end

  // Response side: hold each item off for a random number of cycles, with
  // calm stretches in between; once, on request, hold off for a long time.
  initial begin : rsp_side
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rsp_stall   <= 1'b1;
        rx_hold_req <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 47) == 0)
        rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      answered    <= answered + 1;
      last_write  <= rsp.write_bit;
      last_status <= rsp.status;
    end
  end

  function automatic cmd_t item_of(input kind_t k, input logic pr, input logic ib,
                                   input logic cb);
    cmd_t c;
    c.kind     = k;
    c.presence = pr;
    c.id_bit   = ib;
    c.cmp_bit  = cb;
    return c;
  endfunction

  // Append the CRC-8 of the 56 low bits as the top byte of a ROM identity.
  function automatic logic [ROM_BITS-1:0] with_crc(input logic [CRC_BITS-1:0] body);
    logic [CRC_W-1:0] acc;
    logic             fb;
    acc = '0;
    for (int k = 0; k < CRC_BITS; k++) begin
      fb  = acc[0] ^ body[k];
      acc = acc >> 1;
      if (fb)
        acc = acc ^ CRC_POLY;
    end
    return {acc, body};
  endfunction

  // Offer one item after a random gap and hold it until it is taken. Valid
  // stays high afterwards; the next call or the caller decides its fate.
  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    issued++;
  endtask

  // Drop valid and wait until every item sent so far has been answered.
  task automatic await_reply();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (answered != issued);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) begin
      send_cmd(item_of(kind_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                       1'($urandom)));
      noise_items++;
    end
  endtask

  // One device, sent back to back: the pairs carry its bits whatever the
  // block writes, with an optional forced conflict and corrupted bit.
  task automatic stream_pass(input logic [ROM_BITS-1:0] rom, input bit spoil);
    int unsigned split_at;
    logic        id_b;
    logic        cmp_b;
    if (spoil)
      rom[$urandom_range(0, ROM_BITS - 1)] ^= 1'b1;
    split_at = $urandom_range(0, 2 * ROM_BITS - 1);
    send_cmd(item_of(KIND_START, 1'b1, 1'($urandom), 1'($urandom)));
    for (int p = 0; p < ROM_BITS; p++) begin
      id_b  = (p == split_at) ? 1'b0 : rom[p];
      cmp_b = (p == split_at) ? 1'b0 : !rom[p];
      send_cmd(item_of(KIND_BIT, 1'($urandom), id_b, cmp_b));
    end
  endtask

  // Fill the bus with devices that share most of their bits.
  task automatic fill_bus(input int unsigned count, input bit spoil);
    logic [CRC_BITS-1:0] body;
    body     = CRC_BITS'({$urandom, $urandom});
    bus_size = count;
    for (int i = 0; i < count; i++) begin
      if (i != 0)
        repeat ($urandom_range(1, 3)) body[$urandom_range(0, CRC_BITS - 1)] ^= 1'b1;
      bus_rom[i] = with_crc(body);
    end
    if (spoil)
      bus_rom[$urandom_range(0, count - 1)][$urandom_range(0, ROM_BITS - 1)] ^= 1'b1;
  endtask

  // One search pass against the modelled bus, item by item. Now and then
  // miss the presence pulse, lose every device mid-pass, or walk away.
  task automatic search_pass();
    int unsigned upset;
    int unsigned cut;
    logic        id_b;
    logic        cmp_b;
    upset    = $urandom_range(0, 15);
    cut      = $urandom_range(0, ROM_BITS - 1);
    bus_live = '1;
    send_cmd(item_of(KIND_START, upset != 0, 1'($urandom), 1'($urandom)));
    await_reply();
    if (last_status != ST_STARTED)
      return;
    for (int p = 0; p < ROM_BITS; p++) begin
      if (upset == 2 && p == cut)
        return;                          // the next start abandons this pass
      // wired-and of the true and complement bits of the devices still in
      id_b  = 1'b1;
      cmp_b = 1'b1;
      for (int i = 0; i < bus_size; i++) begin
        if (bus_live[i]) begin
          id_b  = id_b & bus_rom[i][p];
          cmp_b = cmp_b & !bus_rom[i][p];
        end
      end
      if (upset == 1 && p == cut) begin
        id_b  = 1'b1;
        cmp_b = 1'b1;
      end
      send_cmd(item_of(KIND_BIT, 1'($urandom), id_b, cmp_b));
      await_reply();
      for (int i = 0; i < bus_size; i++)
        if (bus_rom[i][p] != last_write)
          bus_live[i] = 1'b0;
      if (last_status != ST_BIT_DONE)
        return;
    end
  endtask

  // Walk the tree until the block says the search is finished, or give up
  // after two passes more than there are devices.
  task automatic run_scan();
    fill_bus($urandom_range(1, MAX_DEVICES), $urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) != 0)
      send_cmd(item_of(KIND_RESTART, 1'($urandom), 1'($urandom), 1'($urandom)));
    for (int n = 0; n < bus_size + 2; n++) begin
      search_pass();
      if (last_status == ST_FINISHED)
        break;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored items, presence, conflict, dropout, abandon, restart.
    send_cmd(item_of(KIND_BIT,     1'b1, 1'b1, 1'b1));   // no pass open yet
    send_cmd(item_of(KIND_UNDEF,   1'b1, 1'b1, 1'b1));
    send_cmd(item_of(KIND_START,   1'b0, 1'b0, 1'b0));   // nobody answers reset
    send_cmd(item_of(KIND_START,   1'b1, 1'b0, 1'b0));
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b0, 1'b1));
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b1, 1'b0));
    send_cmd(item_of(KIND_BIT,     1'b1, 1'b0, 1'b0));   // devices disagree
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b1, 1'b1));   // devices gone
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b0, 1'b1));   // pass already closed
    send_cmd(item_of(KIND_START,   1'b1, 1'b1, 1'b1));
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b1, 1'b0));
    send_cmd(item_of(KIND_START,   1'b1, 1'b0, 1'b1));   // abandon mid-pass
    send_cmd(item_of(KIND_BIT,     1'b0, 1'b0, 1'b0));
    send_cmd(item_of(KIND_RESTART, 1'b1, 1'b1, 1'b1));
    send_cmd(item_of(KIND_RESTART, 1'b0, 1'b0, 1'b0));
    send_cmd(item_of(KIND_UNDEF,   1'b0, 1'b0, 1'b0));

    // Back-pressure: the response side sits still while a whole stream is
    // offered without gaps, so the block must stall its command side.
    rx_hold_req <= 1'b1;
    tx_calm = 1'b1;
    stream_pass(with_crc(CRC_BITS'({$urandom, $urandom})), 1'b0);

    while (issued - noise_items < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0, 1, 2: run_scan();
        3, 4, 5: begin
          if ($urandom_range(0, 3) != 0)
            send_cmd(item_of(KIND_RESTART, 1'($urandom), 1'($urandom), 1'($urandom)));
          stream_pass(with_crc(CRC_BITS'({$urandom, $urandom})),
                      $urandom_range(0, 3) == 0);
        end
        default: send_noise($urandom_range(4, 16));
      endcase
    end

    // Drain: everything owed must come back, then let the pipe settle.
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS onewire_rom_search");
    else
      $display("FAIL onewire_rom_search");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ors_pkg.sv
rtl/core/ors_core.sv
rtl/core/onewire_rom_search.sv
rtl/core/ors_checker.sv
dv/onewire_rom_search_check.sv
dv/onewire_rom_search_test.sv
